/* design/command_frame_deframer_defines.svh */
// assertion macros for the command frame deframer
// expects clk and rst in the scope of the module that uses them
`ifndef COMMAND_FRAME_DEFRAMER_DEFINES_SVH
`define COMMAND_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, off during reset
`define CFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/cfd_pkg.sv */
// shared types and constants of the command frame deframer
// no dependencies
package cfd_pkg;

  // frame parser phase, one-hot
  typedef enum logic [5:0] {
    PH_HUNT_LO = 6'b000001,
    PH_HUNT_HI = 6'b000010,
    PH_HEADER  = 6'b000100,
    PH_BODY    = 6'b001000,
    PH_SUM_LO  = 6'b010000,
    PH_SUM_HI  = 6'b100000
  } phase_t;

  // data type codes
  localparam logic [15:0] TYPE_START  = 16'h20F0;
  localparam logic [15:0] TYPE_STOP   = 16'h2010;
  localparam logic [15:0] TYPE_CONFIG = 16'h0000;

  // device id after reset
  localparam logic [15:0] DEVICE_ID_RESET = 16'h0046;

  // header byte positions
  localparam logic [15:0] HDR_FIRST  = 16'd2;
  localparam logic [15:0] HDR_LEN_LO = 16'd6;
  localparam logic [15:0] HDR_LEN_HI = 16'd7;

  // body byte positions of the type and count words
  localparam logic [15:0] BODY_TYPE_LO  = 16'd0;
  localparam logic [15:0] BODY_TYPE_HI  = 16'd1;
  localparam logic [15:0] BODY_COUNT_LO = 16'd2;
  localparam logic [15:0] BODY_COUNT_HI = 16'd3;

  // shortest body that holds a count word
  localparam logic [15:0] CONFIG_MIN_LEN = 16'd4;

endpackage

/* design/command_frame_deframer.sv */
// command frame deframer: byte parser with an input stage and a result register
// depends on cfd_pkg and command_frame_deframer_defines.svh
//
// Usage:
//   Input channel in_valid / in_ready / rx_byte moves one received byte per word.
//   The block hunts for the device id (low byte first), skips the 8-byte header
//   after reading the length at bytes 6-7, sums the body and checks the 16-bit checksum
//   (low byte = 8-bit sum, high byte 0). One result word leaves on out_valid / out_ready
//   when the last checksum byte of a frame has been handled; other bytes give no word.
//   cfg_write / cfg_data load the device id; it takes effect at the next hunt.
// Timing: the byte that ends a frame is parsed from the input register, and its result
//   word is loaded into the result register, which raises out_valid.
// Throughput: one byte per cycle while no frame-ending byte waits on out_ready, set by the
//   single parse stage between the input register and the result register.
// Reset: rst (synchronous) empties both stages, clears the logging and parameter
//   flags, loads device id 0x0046 and restarts the hunt.
// Stall: while a result word waits on out_ready, bytes that give no result are
//   still parsed; a byte that completes a frame waits in the input stage and
//   in_ready drops until the result register is free again.
`include "command_frame_deframer_defines.svh"

module command_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] data_type,
  output logic [15:0] body_length,
  output logic        checksum_ok,
  output logic        logging_on,
  output logic        params_received
);

  // device id register
  logic [15:0] device_id;

  // input stage
  logic       s1_valid;
  logic [7:0] s1_byte;

  // parser state
  cfd_pkg::phase_t phase, phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] frame_type, frame_type_next;
  logic [15:0] payload_first_word, payload_first_word_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  received_sum_low, received_sum_low_next;
  logic        logging_flag, logging_flag_next;
  logic        params_flag, params_flag_next;

  // control
  logic        out_free;
  logic        proc;
  logic        res_load;
  logic        sum_ok;
  logic [15:0] pos_inc;
  logic [15:0] len_full;

  // only the frame-ending byte needs a free result register
  assign out_free = !out_valid || out_ready;
  assign proc     = s1_valid && (out_free || (phase != cfd_pkg::PH_SUM_HI));
  assign in_ready = !s1_valid || proc;
  assign pos_inc  = byte_position + 16'd1;
  assign len_full = {s1_byte, frame_length[7:0]};

  // device id
  always_ff @(posedge clk) begin
    if (rst) begin
      device_id <= cfd_pkg::DEVICE_ID_RESET;
    end else if (cfg_write) begin
      device_id <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  // parse one byte
  always_comb begin
    phase_next              = phase;
    byte_position_next      = byte_position;
    frame_length_next       = frame_length;
    frame_type_next         = frame_type;
    payload_first_word_next = payload_first_word;
    running_sum_next        = running_sum;
    received_sum_low_next   = received_sum_low;
    logging_flag_next       = logging_flag;
    params_flag_next        = params_flag;
    res_load                = 1'b0;
    sum_ok                  = (s1_byte == 8'h00) && (received_sum_low == running_sum);
    if (proc) begin
      unique case (phase)
        cfd_pkg::PH_HUNT_LO: begin
          if (s1_byte == device_id[7:0]) begin
            phase_next = cfd_pkg::PH_HUNT_HI;
          end
        end
        cfd_pkg::PH_HUNT_HI: begin
          if (s1_byte == device_id[15:8]) begin
            byte_position_next      = cfd_pkg::HDR_FIRST;
            frame_length_next       = 16'h0000;
            frame_type_next         = 16'h0000;
            payload_first_word_next = 16'h0000;
            running_sum_next        = 8'h00;
            received_sum_low_next   = 8'h00;
            phase_next              = cfd_pkg::PH_HEADER;
          end else if (s1_byte == device_id[7:0]) begin
            phase_next = cfd_pkg::PH_HUNT_HI;
          end else begin
            phase_next = cfd_pkg::PH_HUNT_LO;
          end
        end
        cfd_pkg::PH_HEADER: begin
          if (byte_position == cfd_pkg::HDR_LEN_HI) begin
            frame_length_next  = len_full;
            byte_position_next = 16'h0000;
            phase_next = (len_full == 16'h0000) ? cfd_pkg::PH_SUM_LO : cfd_pkg::PH_BODY;
          end else begin
            if (byte_position == cfd_pkg::HDR_LEN_LO) begin
              frame_length_next = {8'h00, s1_byte};
            end
            byte_position_next = pos_inc;
          end
        end
        cfd_pkg::PH_BODY: begin
          running_sum_next = running_sum + s1_byte;
          priority if (byte_position == cfd_pkg::BODY_TYPE_LO) begin
            frame_type_next = {8'h00, s1_byte};
          end else if (byte_position == cfd_pkg::BODY_TYPE_HI) begin
            frame_type_next = {s1_byte, frame_type[7:0]};
          end else if (byte_position == cfd_pkg::BODY_COUNT_LO) begin
            payload_first_word_next = {8'h00, s1_byte};
          end else if (byte_position == cfd_pkg::BODY_COUNT_HI) begin
            payload_first_word_next = {s1_byte, payload_first_word[7:0]};
          end else begin
            payload_first_word_next = payload_first_word;
          end
          byte_position_next = pos_inc;
          if (pos_inc == frame_length) begin
            phase_next = cfd_pkg::PH_SUM_LO;
          end
        end
        cfd_pkg::PH_SUM_LO: begin
          received_sum_low_next = s1_byte;
          phase_next            = cfd_pkg::PH_SUM_HI;
        end
        cfd_pkg::PH_SUM_HI: begin
          res_load = 1'b1;
          if (sum_ok) begin
            priority if (frame_type == cfd_pkg::TYPE_START) begin
              logging_flag_next = 1'b1;
              params_flag_next  = 1'b0;
            end else if (frame_type == cfd_pkg::TYPE_STOP) begin
              logging_flag_next = 1'b0;
              params_flag_next  = 1'b0;
            end else if (frame_type == cfd_pkg::TYPE_CONFIG) begin
              if ((frame_length >= cfd_pkg::CONFIG_MIN_LEN) &&
                  (payload_first_word != 16'h0000)) begin
                params_flag_next = 1'b1;
              end
            end else begin
              logging_flag_next = logging_flag;
            end
          end
          phase_next = cfd_pkg::PH_HUNT_LO;
        end
        default: begin
          phase_next = cfd_pkg::PH_HUNT_LO;
        end
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= cfd_pkg::PH_HUNT_LO;
      byte_position      <= 16'h0000;
      frame_length       <= 16'h0000;
      frame_type         <= 16'h0000;
      payload_first_word <= 16'h0000;
      running_sum        <= 8'h00;
      received_sum_low   <= 8'h00;
      logging_flag       <= 1'b0;
      params_flag        <= 1'b0;
    end else begin
      phase              <= phase_next;
      byte_position      <= byte_position_next;
      frame_length       <= frame_length_next;
      frame_type         <= frame_type_next;
      payload_first_word <= payload_first_word_next;
      running_sum        <= running_sum_next;
      received_sum_low   <= received_sum_low_next;
      logging_flag       <= logging_flag_next;
      params_flag        <= params_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      data_type       <= frame_type;
      body_length     <= frame_length;
      checksum_ok     <= sum_ok;
      logging_on      <= logging_flag_next;
      params_received <= params_flag_next;
    end
  end

  // checks
  `CFD_ASSERT_NEXT(a_result_after_sum, proc && (phase == cfd_pkg::PH_SUM_HI), out_valid,
    "frame end gave no result word")
  `CFD_ASSERT_SAME(a_flags_match, out_valid,
    (logging_on == logging_flag) && (params_received == params_flag),
    "pending result flags differ from flag state")
  `CFD_ASSERT_SAME(a_body_in_range, phase == cfd_pkg::PH_BODY, byte_position < frame_length,
    "body position past frame length")
  `CFD_ASSERT_SAME(a_header_in_range, phase == cfd_pkg::PH_HEADER,
    (byte_position >= cfd_pkg::HDR_FIRST) && (byte_position <= cfd_pkg::HDR_LEN_HI),
    "header position out of range")

endmodule
